// ===== sv/ssjb_pkg.sv =====
// package for the sequence sorted jitter buffer
// depth, frame size, operation codes and the cell control struct; no dependencies
`default_nettype none
package ssjb_pkg;
    localparam int unsigned BufferDepth = 128;
    localparam int unsigned CountW = $clog2(BufferDepth + 1);
    localparam logic [15:0] FrameBytes = 16'd1920;
    localparam logic [6:0] CapLimitReset = 7'd120;
    localparam logic [15:0] StaleReset = 16'd10;

    localparam logic [1:0] ModePush = 2'd0;
    localparam logic [1:0] ModePop = 2'd1;
    localparam logic [1:0] ModeStats = 2'd2;

    localparam logic CfgCapLimit = 1'b0;
    localparam logic CfgStale = 1'b1;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] size;
        logic [31:0] pref;
    } entry_t;

    // broadcast control for every cell of the row
    typedef struct packed {
        logic        ins;    // insert new entry
        logic        shl;    // shift towards the front
        entry_t      data;
    } cell_ctrl_t;
endpackage
`default_nettype wire

// ===== sv/ssjb_cell.sv =====
// one slot of the sorted row: holds an entry and a valid bit
// depends on ssjb_pkg
`default_nettype none
module ssjb_cell
    import ssjb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     prev_entry,
    input  wire logic       prev_vld,
    input  wire logic       prev_lt,
    input  wire entry_t     next_entry,
    input  wire logic       next_vld,
    output entry_t          entry,
    output logic            vld,
    output logic            lt
);
    entry_t entry_reg, entry_next;
    logic   vld_reg, vld_next;

    assign entry = entry_reg;
    assign vld   = vld_reg;
    // this slot holds a smaller sequence number than the one pushed
    assign lt    = vld_reg && (entry_reg.seq < ctrl.data.seq);

    always_comb begin
        entry_next = entry_reg;
        vld_next   = vld_reg;
        if (ctrl.ins) begin
            if (!lt) begin
                if (prev_lt) begin
                    entry_next = ctrl.data;
                    vld_next   = 1'b1;
                end else begin
                    entry_next = prev_entry;
                    vld_next   = prev_vld;
                end
            end
        end else if (ctrl.shl) begin
            entry_next = next_entry;
            vld_next   = next_vld;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/ssjb_div.sv =====
// restoring divider for the drop percentage, one quotient bit per cycle
// depends on ssjb_pkg
`default_nettype none
module ssjb_div
    import ssjb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [38:0] num,
    input  wire logic [32:0] den,
    output logic             done,
    output logic [6:0]       quo
);
    logic [38:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [32:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    assign done = busy_reg && (cnt_reg == 6'd0);
    assign quo  = q_reg[6:0];

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[32:0], q_reg[38]};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = 6'd39;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 6'd1;
                if (trial >= {1'b0, d_reg}) begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[37:0], 1'b1};
                end else begin
                    r_next = trial;
                    q_next = {q_reg[37:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= den;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/sequence_sorted_jitter_buffer.sv =====
// jitter buffer top level: a row of sorted cells, a sequencer and the percentage divider
// push: insert, then evict from the front while the fill is above the cap limit;
// pop: front entry, skipping stale ones; stats: bit-serial divider; one item at a time
// result held in an output register; next item taken only after its transfer
// synchronous active-low reset empties the row, clears counters, loads register defaults
`default_nettype none
module sequence_sorted_jitter_buffer
    import ssjb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [15:0] s_seq_in,
    input  wire logic [15:0] s_size_in,
    input  wire logic [31:0] s_payload_ref_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [15:0]      m_seq_out,
    output logic [15:0]      m_size_out,
    output logic [31:0]      m_payload_ref_out,
    output logic [6:0]       m_drop_pct,
    output logic [7:0]       m_fill_level,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StEvict = 3'd1;
    localparam logic [2:0] StStale = 3'd2;
    localparam logic [2:0] StDiv   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [2:0]        st_reg, st_next;
    logic [6:0]        cap_reg;
    logic [15:0]       stale_reg;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [15:0]       last_reg, last_next;
    logic [31:0]       rcv_reg, rcv_next, drp_reg, drp_next;
    logic              found_reg, found_next;
    entry_t            res_reg, res_next;
    logic [6:0]        pct_reg, pct_next;
    logic              ovld_reg, ovld_next;
    logic [CountW-1:0] limit;
    logic              div_start, div_done;
    logic [6:0]        div_quo;
    logic [32:0]       total;
    logic [15:0]       age;

    cell_ctrl_t ctrl;
    entry_t     c_entry [BufferDepth];
    logic       c_vld   [BufferDepth];
    logic       c_lt    [BufferDepth];

    genvar g;
    generate
        for (g = 0; g < BufferDepth; g++) begin : g_cell
            entry_t pe, ne;
            logic   pv, plt, nv;
            if (g == 0) begin : g_first
                assign pe = ctrl.data;
                assign pv = 1'b0;
                assign plt = 1'b1;
            end else begin : g_mid
                assign pe = c_entry[g-1];
                assign pv = c_vld[g-1];
                assign plt = c_lt[g-1];
            end
            if (g == BufferDepth - 1) begin : g_last
                assign ne = c_entry[g];
                assign nv = 1'b0;
            end else begin : g_body
                assign ne = c_entry[g+1];
                assign nv = c_vld[g+1];
            end
            ssjb_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                .prev_entry(pe), .prev_vld(pv), .prev_lt(plt),
                .next_entry(ne), .next_vld(nv),
                .entry(c_entry[g]), .vld(c_vld[g]), .lt(c_lt[g])
            );
        end
    endgenerate

    assign total = {1'b0, rcv_reg} + {1'b0, drp_reg};
    ssjb_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({1'd0, drp_reg, 6'd0} + {2'd0, drp_reg, 5'd0} + {5'd0, drp_reg, 2'd0}),
        .den(total), .done(div_done), .quo(div_quo)
    );

    assign limit = ({1'b0, cap_reg} > CountW'(BufferDepth - 1))
                   ? CountW'(BufferDepth - 1) : CountW'(cap_reg);
    assign age = last_reg + 16'd1 - c_entry[0].seq;

    assign s_ready   = (st_reg == StIdle) || (st_reg == StOut && !ovld_reg);
    assign cfg_ready = 1'b1;
    assign m_valid   = ovld_reg;
    assign m_found   = found_reg;
    assign m_seq_out = res_reg.seq;
    assign m_size_out = res_reg.size;
    assign m_payload_ref_out = res_reg.pref;
    assign m_drop_pct = pct_reg;
    assign m_fill_level = 8'(cnt_reg);

    always_comb begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        rcv_next   = rcv_reg;
        drp_next   = drp_reg;
        found_next = found_reg;
        res_next   = res_reg;
        pct_next   = pct_reg;
        ovld_next  = ovld_reg;
        div_start  = 1'b0;
        ctrl.ins   = 1'b0;
        ctrl.shl   = 1'b0;
        ctrl.data.seq  = s_seq_in;
        ctrl.data.size = (s_size_in > FrameBytes) ? FrameBytes : s_size_in;
        ctrl.data.pref = s_payload_ref_in;
        if (ovld_reg && m_ready) ovld_next = 1'b0;
        case (st_reg)
            StIdle, StOut: begin
                if (st_reg == StIdle || !ovld_reg) begin
                    if (s_valid) begin
                        found_next = 1'b0;
                        res_next   = '0;
                        pct_next   = '0;
                        st_next    = StOut;
                        case (s_mode)
                            ModePush: begin
                                ctrl.ins = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                if (rcv_reg != '1) rcv_next = rcv_reg + 32'd1;
                                st_next = StEvict;
                            end
                            ModePop: st_next = StStale;
                            ModeStats: begin
                                div_start = 1'b1;
                                st_next   = StDiv;
                            end
                            default: ovld_next = 1'b1;
                        endcase
                    end else if (st_reg == StOut) begin
                        st_next = StIdle;
                    end
                end
            end
            StEvict: begin
                if (cnt_reg > limit) begin
                    ctrl.shl = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (drp_reg != '1) drp_next = drp_reg + 32'd1;
                end else begin
                    ovld_next = 1'b1;
                    st_next   = StOut;
                end
            end
            StStale: begin
                if (cnt_reg != '0) begin
                    ctrl.shl = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (age <= stale_reg) begin
                        found_next = 1'b1;
                        res_next   = c_entry[0];
                        last_next  = c_entry[0].seq;
                        ovld_next  = 1'b1;
                        st_next    = StOut;
                    end
                end else begin
                    ovld_next = 1'b1;
                    st_next   = StOut;
                end
            end
            StDiv: begin
                if (div_done) begin
                    pct_next  = (total == '0) ? 7'd0 : div_quo;
                    rcv_next  = '0;
                    drp_next  = '0;
                    ovld_next = 1'b1;
                    st_next   = StOut;
                end
            end
            default: st_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        found_reg <= found_next;
        pct_reg <= pct_next;
        if (!aresetn) begin
            st_reg    <= StIdle;
            cnt_reg   <= '0;
            last_reg  <= '0;
            rcv_reg   <= '0;
            drp_reg   <= '0;
            ovld_reg  <= 1'b0;
            cap_reg   <= CapLimitReset;
            stale_reg <= StaleReset;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            rcv_reg  <= rcv_next;
            drp_reg  <= drp_next;
            ovld_reg <= ovld_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CfgCapLimit: cap_reg <= cfg_data[6:0];
                    CfgStale:    stale_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire
